// ----- rtl/adpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adpt_pkg: shared types and constants
// Widths, register indexes and FSM states of the adaptive deadline throttle.
// ----------------------------------------------------------------------------
package adpt_pkg;

    localparam int TIME_W    = 48;           // time ticks and work counts
    localparam int IVL_W     = 17;           // interval, 1 .. MAX_IVL
    localparam int VAR_W     = 9;            // variability register
    localparam int VI_W      = VAR_W + IVL_W; // variability * interval
    localparam int PROD_W    = VI_W + TIME_W; // exact product before saturation
    localparam int EST_W     = 64;           // saturated product and estimate
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 64;

    localparam int MUL_STEPS = VI_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int DIV_STEPS = EST_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [IVL_W-1:0] MAX_IVL     = IVL_W'(65536);
    localparam logic [TIME_W-1:0] SLIDE_LIMIT = TIME_W'(15);
    localparam logic [EST_W-1:0] EST_FLOOR   = EST_W'(100000);
    localparam logic [VAR_W-1:0] VAR_RESET   = VAR_W'(64);

    localparam logic [1:0] REG_DEADLINE  = 2'd0;
    localparam logic [1:0] REG_MARGIN    = 2'd1;
    localparam logic [1:0] REG_VARIAB    = 2'd2;
    localparam logic [1:0] REG_UNLIMITED = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_DECIDE,
        ST_HALVE,
        ST_OUT
    } adpt_state_t;

endpackage
`default_nettype wire

// ----- rtl/adpt_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adpt_mul: bit-serial saturating multiplier
// Shift-add over the multiplier bits, LSB first, one bit per cycle.
// ----------------------------------------------------------------------------
module adpt_mul
    import adpt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [VI_W-1:0]   a,
    input  wire logic [TIME_W-1:0] b,
    output logic                   done,
    output logic [EST_W-1:0]       prod
);

    logic [TIME_W-1:0]    hi_reg, hi_next;
    logic [VI_W-1:0]      lo_reg, lo_next;
    logic [TIME_W-1:0]    b_reg, b_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [TIME_W:0]      sum;
    logic [PROD_W-1:0]    full;

    assign sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, b_reg} : {(TIME_W+1){1'b0}});
    assign full = {hi_reg, lo_reg};
    // anything above 64 bits saturates
    assign prod = (|full[PROD_W-1:EST_W]) ? {EST_W{1'b1}} : full[EST_W-1:0];
    assign done = done_reg;

    always_comb begin
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            hi_next   = '0;
            lo_next   = a;
            b_next    = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            hi_next  = sum[TIME_W:1];
            lo_next  = {sum[0], lo_reg[VI_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        b_reg  <= b_next;
    end

endmodule
`default_nettype wire

// ----- rtl/adpt_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adpt_div: bit-serial restoring divider
// One quotient bit per cycle, MSB first; divisor must be nonzero.
// ----------------------------------------------------------------------------
module adpt_div
    import adpt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [EST_W-1:0]  dividend,
    input  wire logic [TIME_W-1:0] divisor,
    output logic                   done,
    output logic [EST_W-1:0]       quot
);

    logic [EST_W-1:0]     q_reg, q_next;
    logic [TIME_W-1:0]    r_reg, r_next;
    logic [TIME_W-1:0]    d_reg, d_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [TIME_W:0]      trial;
    logic [TIME_W:0]      diff;
    logic                 ge;

    assign trial = {r_reg, q_reg[EST_W-1]};
    assign ge    = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};
    assign quot  = q_reg;
    assign done  = done_reg;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // partial remainder stays below the divisor
            r_next   = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            q_next   = {q_reg[EST_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

endmodule
`default_nettype wire

// ----- rtl/adaptive_deadline_poll_throttle_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_deadline_poll_throttle_core: poll interval throttle with deadline
// Decides how many work units software may run before it polls again, and
// whether the deadline has passed.
// ----------------------------------------------------------------------------
// One request is handled at a time. A new-loop command and a request in
// unlimited mode go from idle straight to the output state; a check that finds
// the deadline passed goes through the check state first. A regular check runs
// check, prep, the bit-serial multiplier (variability * interval * elapsed),
// the bit-serial divider (one quotient bit per cycle), decide and, when needed,
// interval halving. s_tready is high only while the block is idle;
// the result sits in an output register, so a new request is taken while the
// previous result still waits for m_tready. Registers (APB, 64-bit data,
// 8-byte stride): 0 deadline, 1 deadline_margin, 2 variability, 3 unlimited.
// Write them only while the block is idle.
// ----------------------------------------------------------------------------
module adaptive_deadline_poll_throttle_core
    import adpt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // request channel
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [47:0]       s_tdata,   // [47:0] now
    input  wire logic              s_tuser,   // [0] command (1 = new loop)
    // result channel
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata,   // [16:0] next_interval, rest zero
    output logic                   m_tuser,   // [0] timed_out
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    // configuration registers
    logic [TIME_W-1:0] deadline_reg, deadline_next;
    logic [TIME_W-1:0] margin_reg, margin_next;
    logic [VAR_W-1:0]  var_reg, var_next;
    logic              unl_reg, unl_next;

    // loop state
    logic [TIME_W-1:0] total_reg, total_next;
    logic [TIME_W-1:0] ref_cnt_reg, ref_cnt_next;
    logic [TIME_W-1:0] ref2_cnt_reg, ref2_cnt_next;
    logic [TIME_W-1:0] ref_time_reg, ref_time_next;
    logic [TIME_W-1:0] ref2_time_reg, ref2_time_next;
    logic [IVL_W-1:0]  ivl_reg, ivl_next;

    // per-request working registers
    adpt_state_t       state_reg, state_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] cnt_reg, cnt_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic              rem_neg_reg, rem_neg_next;
    logic [EST_W-1:0]  est_reg, est_next;
    logic              timed_reg, timed_next;

    // output register
    logic              m_tvalid_reg, m_tvalid_next;
    logic              m_timed_reg, m_timed_next;
    logic [IVL_W-1:0]  m_ivl_reg, m_ivl_next;

    // datapath
    logic [TIME_W-1:0] cnt_diff;
    logic [TIME_W-1:0] elapsed;
    logic [VI_W-1:0]   vi;
    logic [TIME_W-1:0] rem_m1;
    logic [IVL_W:0]    ivl_dbl;
    logic              cfg_wr;
    logic              mul_start, mul_done;
    logic [EST_W-1:0]  mul_prod;
    logic              div_start, div_done;
    logic [EST_W-1:0]  div_quot;

    assign cnt_diff = total_reg - ref_cnt_reg;
    // time running backward counts as no elapsed time
    assign elapsed  = (now_reg >= ref_time_reg) ? now_reg - ref_time_reg : '0;
    assign vi       = VI_W'(var_reg) * VI_W'(ivl_reg);
    assign rem_m1   = rem_reg - 1'b1;
    assign ivl_dbl  = {ivl_reg, 1'b0};
    assign cfg_wr   = psel && penable && pwrite;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_timed_reg;
    assign m_tdata  = {{(24 - IVL_W){1'b0}}, m_ivl_reg};
    assign pready   = 1'b1;

    always_comb begin
        case (paddr[4:3])
            REG_DEADLINE:  prdata = {{(DATA_W - TIME_W){1'b0}}, deadline_reg};
            REG_MARGIN:    prdata = {{(DATA_W - TIME_W){1'b0}}, margin_reg};
            REG_VARIAB:    prdata = {{(DATA_W - VAR_W){1'b0}}, var_reg};
            REG_UNLIMITED: prdata = {{(DATA_W - 1){1'b0}}, unl_reg};
            default:       prdata = '0;
        endcase
    end

    adpt_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (vi),
        .b       (elapsed),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    adpt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mul_prod),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quot     (div_quot)
    );

    // control FSM and next-state logic
    always_comb begin
        deadline_next  = deadline_reg;
        margin_next    = margin_reg;
        var_next       = var_reg;
        unl_next       = unl_reg;
        total_next     = total_reg;
        ref_cnt_next   = ref_cnt_reg;
        ref2_cnt_next  = ref2_cnt_reg;
        ref_time_next  = ref_time_reg;
        ref2_time_next = ref2_time_reg;
        ivl_next       = ivl_reg;
        state_next     = state_reg;
        now_next       = now_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        rem_neg_next   = rem_neg_reg;
        est_next       = est_reg;
        timed_next     = timed_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_timed_next   = m_timed_reg;
        m_ivl_next     = m_ivl_reg;
        mul_start      = 1'b0;
        div_start      = 1'b0;

        if (cfg_wr) begin
            case (paddr[4:3])
                REG_DEADLINE:  deadline_next = pwdata[TIME_W-1:0];
                REG_MARGIN:    margin_next   = pwdata[TIME_W-1:0];
                REG_VARIAB:    var_next      = pwdata[VAR_W-1:0];
                REG_UNLIMITED: unl_next      = pwdata[0];
                default:       ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    now_next   = s_tdata;
                    timed_next = 1'b0;
                    if (unl_reg) begin
                        // state untouched, report current interval
                        state_next = ST_OUT;
                    end else if (s_tuser) begin
                        // new loop: interval back to 1, rebase both references
                        ivl_next       = IVL_W'(1);
                        ref_cnt_next   = total_reg;
                        ref2_cnt_next  = total_reg;
                        ref_time_next  = s_tdata;
                        ref2_time_next = s_tdata;
                        state_next     = ST_OUT;
                    end else begin
                        total_next = total_reg + TIME_W'(ivl_reg);
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (now_reg > deadline_reg) begin
                    timed_next = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    // slide the reference window once more than 15 counts passed since the last slide
                    if ((total_reg - ref2_cnt_reg) > SLIDE_LIMIT) begin
                        ref_cnt_next   = ref2_cnt_reg;
                        ref_time_next  = ref2_time_reg;
                        ref2_cnt_next  = total_reg;
                        ref2_time_next = now_reg;
                    end
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                mul_start    = 1'b1;
                cnt_next     = (cnt_diff == '0) ? TIME_W'(1) : cnt_diff;
                rem_neg_next = margin_reg < now_reg;
                rem_next     = (margin_reg < now_reg) ? '0 : margin_reg - now_reg;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                if (mul_done) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    est_next   = div_quot;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // double when 4*est < remaining margin
                if (!rem_neg_reg && (rem_reg != '0) &&
                    (est_reg <= EST_W'(rem_m1 >> 2))) begin
                    if (ivl_reg < MAX_IVL) begin
                        ivl_next = (ivl_dbl > {1'b0, MAX_IVL}) ? MAX_IVL
                                                                : ivl_dbl[IVL_W-1:0];
                    end
                    state_next = ST_OUT;
                end else if (rem_neg_reg || (est_reg > EST_W'(rem_reg))) begin
                    state_next = ST_HALVE;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_HALVE: begin
                if ((est_reg > EST_FLOOR) &&
                    (rem_neg_reg || (est_reg > EST_W'(rem_reg))) &&
                    (ivl_reg > IVL_W'(1))) begin
                    est_next = est_reg >> 1;
                    ivl_next = ivl_reg >> 1;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_timed_next  = timed_reg;
                    m_ivl_next    = ivl_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            deadline_reg  <= '0;
            margin_reg    <= '0;
            var_reg       <= VAR_RESET;
            unl_reg       <= 1'b0;
            total_reg     <= '0;
            ref_cnt_reg   <= '0;
            ref2_cnt_reg  <= '0;
            ref_time_reg  <= '0;
            ref2_time_reg <= '0;
            ivl_reg       <= IVL_W'(1);
        end else begin
            state_reg     <= state_next;
            m_tvalid_reg  <= m_tvalid_next;
            deadline_reg  <= deadline_next;
            margin_reg    <= margin_next;
            var_reg       <= var_next;
            unl_reg       <= unl_next;
            total_reg     <= total_next;
            ref_cnt_reg   <= ref_cnt_next;
            ref2_cnt_reg  <= ref2_cnt_next;
            ref_time_reg  <= ref_time_next;
            ref2_time_reg <= ref2_time_next;
            ivl_reg       <= ivl_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        rem_neg_reg <= rem_neg_next;
        est_reg     <= est_next;
        timed_reg   <= timed_next;
        m_timed_reg <= m_timed_next;
        m_ivl_reg   <= m_ivl_next;
    end

    // interval stays in 1 .. MAX_IVL
    a_ivl_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (ivl_reg != '0) && (ivl_reg <= MAX_IVL))
        else $error("interval out of range");

    // one request at a time: no new request right after one is taken
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while busy");

    // divider never sees a zero divisor
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (cnt_reg != '0))
        else $error("zero divisor");

    // serial units report done only while the FSM waits for them
    a_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_done |-> (state_reg == ST_MUL)) and (div_done |-> (state_reg == ST_DIV)))
        else $error("unit done outside its wait state");

endmodule
`default_nettype wire

// ----- bench/adaptive_deadline_poll_throttle_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_deadline_poll_throttle_core_test: self-checking bench for the throttle
// Drives check and new-loop requests over the stream ports and programs the
// registers over APB. An in-bench predictor computes each expected result,
// and every result the block returns is compared with it in order.
// ----------------------------------------------------------------------------
module adaptive_deadline_poll_throttle_core_test;
    import adpt_pkg::*;

    // Run limit. The slowest legal run is about 870 requests, each a full check at
    // worst, plus sender gaps, receiver stalls and one long hold-off.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int M_DATA_W    = 24;

    typedef enum logic {
        CMD_CHECK    = 1'b0,
        CMD_NEW_LOOP = 1'b1
    } throttle_cmd_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic             timed_out;
        logic [IVL_W-1:0] next_interval;
    } throttle_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds its own copy of the registers and the loop state, works
    // out the result of every accepted request and checks results in order.
    // ------------------------------------------------------------------------
    class throttle_scoreboard;
        logic [TIME_W-1:0] deadline, margin;
        logic [VAR_W-1:0]  variability;
        logic              unlimited;
        logic [TIME_W-1:0] total_count, ref_count, ref2_count, ref_time, ref2_time;
        logic [IVL_W-1:0]  interval;
        throttle_result_t  expected_results[$];
        int mismatches, results_seen, timeouts_seen, capped_seen, new_loops;

        function new();
            deadline    = '0;
            margin      = '0;
            variability = VAR_RESET;
            unlimited   = 1'b0;
            total_count = '0;
            ref_count   = '0;
            ref2_count  = '0;
            ref_time    = '0;
            ref2_time   = '0;
            interval    = IVL_W'(1);
        endfunction

        function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_DEADLINE:  deadline    = value[TIME_W-1:0];
                REG_MARGIN:    margin      = value[TIME_W-1:0];
                REG_VARIAB:    variability = value[VAR_W-1:0];
                REG_UNLIMITED: unlimited   = value[0];
                default: ;
            endcase
        endfunction

        // Next interval and timeout flag for one request; advances the loop state.
        function throttle_result_t throttle_step(throttle_cmd_t cmd, logic [TIME_W-1:0] now);
            throttle_result_t  r;
            logic [TIME_W-1:0] since_slide, elapsed, count, remaining;
            logic [127:0]      product;
            logic [EST_W-1:0]  estimate;
            logic              past_margin;
            r.timed_out     = 1'b0;
            r.next_interval = interval;
            if (unlimited)
                return r;
            if (cmd == CMD_NEW_LOOP) begin
                interval   = IVL_W'(1);
                ref_count  = total_count;
                ref2_count = total_count;
                ref_time   = now;
                ref2_time  = now;
                r.next_interval = IVL_W'(1);
                return r;
            end
            total_count = total_count + TIME_W'(interval);
            if (now > deadline) begin
                r.timed_out = 1'b1;
                return r;
            end
            since_slide = total_count - ref2_count;
            if (since_slide > SLIDE_LIMIT) begin
                ref_count  = ref2_count;
                ref_time   = ref2_time;
                ref2_count = total_count;
                ref2_time  = now;
            end
            elapsed = (now >= ref_time) ? now - ref_time : '0;
            count   = total_count - ref_count;
            if (count == 0)
                count = TIME_W'(1);
            product  = 128'(variability) * 128'(interval) * 128'(elapsed);
            estimate = (product[127:64] != 0) ? '1 : product[63:0];
            estimate = estimate / EST_W'(count);
            past_margin = margin < now;
            remaining   = past_margin ? '0 : margin - now;
            if (!past_margin && remaining != 0 && estimate <= EST_W'((remaining - 1) >> 2)) begin
                if (interval < MAX_IVL)
                    interval = (interval >= MAX_IVL / 2) ? MAX_IVL : interval << 1;
            end else if (past_margin || estimate > EST_W'(remaining)) begin
                while (estimate > EST_FLOOR && (past_margin || estimate > EST_W'(remaining))
                       && interval > 1) begin
                    estimate = estimate >> 1;
                    interval = interval >> 1;
                end
            end
            r.next_interval = interval;
            return r;
        endfunction

        function void note_request(throttle_cmd_t cmd, logic [TIME_W-1:0] now);
            if (cmd == CMD_NEW_LOOP)
                new_loops++;
            expected_results.push_back(throttle_step(cmd, now));
        endfunction

        function void check_result(logic timed_out, logic [M_DATA_W-1:0] data);
            throttle_result_t want;
            if (expected_results.size() == 0) begin
                $error("result arrived with no request outstanding: timed_out %0b interval %0d",
                       timed_out, data[IVL_W-1:0]);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            results_seen++;
            if (want.timed_out)
                timeouts_seen++;
            if (want.next_interval == MAX_IVL)
                capped_seen++;
            if (timed_out !== want.timed_out) begin
                $error("timed_out: expected %0b, got %0b", want.timed_out, timed_out);
                mismatches++;
            end
            if (data[IVL_W-1:0] !== want.next_interval) begin
                $error("next_interval: expected %0d, got %0d", want.next_interval,
                       data[IVL_W-1:0]);
                mismatches++;
            end
            if (data[M_DATA_W-1:IVL_W] !== '0) begin
                $error("m_tdata padding: expected 0, got %0h", data[M_DATA_W-1:IVL_W]);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [47:0]         s_tdata;    // [47:0] now
    logic                s_tuser;    // [0] command
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;    // [16:0] next_interval, [23:17] zero
    logic                m_tuser;    // [0] timed_out
    logic                psel, penable, pwrite, pready;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata, prdata;

    throttle_scoreboard sb = new();

    // Idle control: percentages per cycle, plus a one-shot long receiver hold.
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    int          hold_req  = 0;
    int          hold_left = 0;
    int          cycle_count = 0;
    // Software's notion of "now", advanced before each check of a well-formed loop.
    logic [TIME_W-1:0] clock_now;

    adaptive_deadline_poll_throttle_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 8 ns clock
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    // hold_left is counted here so the sender keeps offering during the hold.
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result monitor: m_tready/m_tvalid are read as they stood before the edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic set_idle(input idle_mode_t mode);
        gap_pct   = (mode == IDLE_SENDER)   ? 61 : (mode == IDLE_BOTH) ? 14 : 0;
        stall_pct = (mode == IDLE_RECEIVER) ? 61 : (mode == IDLE_BOTH) ? 14 : 0;
    endtask

    // Offer one request and hold it until accepted. s_tvalid is only lowered by
    // a gap or by wait_drain, so back-to-back requests never toggle it in a step.
    task automatic send_request(input throttle_cmd_t cmd, input logic [TIME_W-1:0] t);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= t;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, t);
    endtask

    // Stop offering and wait for every outstanding result; one request is in
    // flight at most, and the spare wait at the end covers the block's return to idle.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the edge
    // where psel, penable, pwrite and pready are all high. The task then idles
    // with psel low so the next transfer starts in a later step.
    task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic reprogram(input logic [DATA_W-1:0] dl, input logic [DATA_W-1:0] mg,
                             input logic [DATA_W-1:0] variab);
        wait_drain();
        apb_write(REG_DEADLINE, dl);
        apb_write(REG_MARGIN, mg);
        apb_write(REG_VARIAB, variab);
    endtask

    // Time advance between two polls: mostly short, sometimes a big jump,
    // now and then the clock steps backward.
    function automatic logic [TIME_W-1:0] next_step();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 45) return TIME_W'($urandom_range(0, 16));
        if (p < 75) return TIME_W'($urandom_range(0, 4000));
        if (p < 92) return TIME_W'($urandom_range(0, 400000));
        if (p < 97) return TIME_W'($urandom_range(0, 50_000_000));
        return -TIME_W'($urandom_range(1, 5000));
    endfunction

    // Mostly well-formed loops (new-loop then a run of checks on a moving
    // clock); the rest are lone requests at arbitrary times.
    task automatic run_loops(input int n_items);
        int sent, len, k;
        logic [63:0] noise;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 8) begin
                noise = {$urandom, $urandom};
                send_request(noise[63] ? CMD_NEW_LOOP : CMD_CHECK, noise[TIME_W-1:0]);
                sent++;
            end else begin
                len = $urandom_range(4, 40);
                send_request(CMD_NEW_LOOP, clock_now);
                sent++;
                for (k = 0; k < len && sent < n_items; k++) begin
                    clock_now = clock_now + next_step();
                    send_request(CMD_CHECK, clock_now);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [TIME_W-1:0] dl;
        int p;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        clock_now = TIME_W'({$urandom, $urandom});
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, no idling. Reset registers: deadline 0, margin 0.
        set_idle(IDLE_NONE);
        send_request(CMD_CHECK, '0);            // now equal to deadline: not late
        send_request(CMD_CHECK, '1);            // far past the deadline
        send_request(CMD_NEW_LOOP, '1);

        // Open deadline and margin: zero elapsed time lets the interval double,
        // then a huge jump forces repeated halving.
        reprogram('1, '1, 256);
        send_request(CMD_NEW_LOOP, '0);
        repeat (4) send_request(CMD_CHECK, '0);
        send_request(CMD_CHECK, 48'h8000_0000_0000);
        // Clock running backward since the reference.
        send_request(CMD_NEW_LOOP, 48'd1000);
        send_request(CMD_CHECK, 48'd500);
        send_request(CMD_CHECK, 48'd1500);

        // Margin already passed; zero variability gives a zero estimate.
        reprogram('1, '0, 0);
        send_request(CMD_CHECK, 48'd2000);
        // Variability beyond the usual range with the margin passed.
        reprogram('1, 100, 511);
        send_request(CMD_CHECK, 48'd5000);
        send_request(CMD_CHECK, 48'd900000);

        // Unlimited mode: never late, state frozen.
        wait_drain();
        apb_write(REG_UNLIMITED, 1);
        send_request(CMD_CHECK, '1);
        send_request(CMD_NEW_LOOP, 48'd7);
        wait_drain();
        apb_write(REG_UNLIMITED, 0);
        reprogram('0, '1, 64);
        send_request(CMD_CHECK, 48'd1);         // one tick late

        // Random phases, each with its own register setting and one of four idle patterns.
        for (p = 0; p < 8; p++) begin
            wait_drain();
            set_idle(idle_mode_t'(p % 4));
            dl = clock_now + TIME_W'($urandom_range(1_000_000, 100_000_000));
            case (p)
                0: reprogram(dl, dl + 62500 + $urandom_range(0, 4096), 64);
                1: reprogram(dl, dl + 62500 + $urandom_range(0, 4096), 1);
                2: reprogram(dl, dl + 62500 + $urandom_range(0, 4096), 256);
                3: reprogram(dl, dl + 62500, $urandom_range(1, 256));
                4: reprogram(dl, dl + 62500 + $urandom_range(0, 4096), $urandom_range(1, 256));
                5: reprogram('1, '1, 511);
                6: reprogram(dl, dl - TIME_W'($urandom_range(0, 50_000_000)),
                             $urandom_range(1, 256));
                default: reprogram(dl, dl + 62500, 0);
            endcase
            if (p == 3)
                hold_req = 2000;                 // receiver holds off; input backs up
            if (p == 4) begin
                apb_write(REG_UNLIMITED, 1);
                run_loops(30);
                wait_drain();
                apb_write(REG_UNLIMITED, 0);
                run_loops(76);
            end else if (p == 2) begin
                run_loops(50);
                wait_drain();                    // sender pauses until all results are in
                run_loops(56);
            end else begin
                run_loops(106);
            end
        end

        wait_drain();
        repeat (200) @(posedge aclk);

        $display("Covered %0d results (%0d new loops, %0d timeouts, %0d at the interval cap)",
                 sb.results_seen, sb.new_loops, sb.timeouts_seen, sb.capped_seen);
        $display("across 8 register settings, unlimited mode and four idle patterns.");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
